FILE: sv/evsb_pkg.sv
// ----------------------------------------------------------------------------
// evsb_pkg
// Shared types and constants of the energy voice activity detector.
// ----------------------------------------------------------------------------
package evsb_pkg;

    localparam int MAX_CHUNK_SAMPLES = 2048;
    localparam int CNT_W             = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SAMPLE_W          = 16;
    localparam int MS_W              = 10;
    localparam int TIME_W            = 16;
    localparam int THR_W             = 16;
    localparam int SQ_W              = 2 * SAMPLE_W;
    localparam int THR2_W            = 2 * THR_W;
    localparam int SUM_W             = 43;
    localparam int TACC_W            = THR2_W + CNT_W;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 4;

    localparam logic [THR_W-1:0]  RMS_LEVEL_RESET   = 16'd400;
    localparam logic [TIME_W-1:0] PAUSE_LIMIT_RESET = 16'd600;
    localparam logic [TIME_W-1:0] MAX_SPEECH_RESET  = 16'd8000;
    localparam logic [TIME_W-1:0] TIME_MAX          = '1;

    typedef enum logic [1:0] {
        REG_VAD_ENABLE,
        REG_RMS_LEVEL,
        REG_PAUSE_LIMIT,
        REG_MAX_SPEECH
    } t_reg_idx;

    typedef struct packed {
        logic              vad_enable;
        logic [THR_W-1:0]  rms_level;
        logic [TIME_W-1:0] pause_limit_ms;
        logic [TIME_W-1:0] max_speech_ms;
    } t_cfg;

    typedef struct packed {
        logic            chunk_end;
        logic [MS_W-1:0] chunk_ms;
        logic            has_text;
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
        logic silent;
    } t_chunk;

endpackage

FILE: sv/evsb_regs.sv
// ----------------------------------------------------------------------------
// evsb_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module evsb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [evsb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [evsb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [evsb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output evsb_pkg::t_cfg                  o_cfg
);
    import evsb_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vad_enable     <= 1'b0;
            r_cfg.rms_level      <= RMS_LEVEL_RESET;
            r_cfg.pause_limit_ms <= PAUSE_LIMIT_RESET;
            r_cfg.max_speech_ms  <= MAX_SPEECH_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_VAD_ENABLE:  r_cfg.vad_enable     <= pwdata[0];
                REG_RMS_LEVEL:   r_cfg.rms_level      <= pwdata[THR_W-1:0];
                REG_PAUSE_LIMIT: r_cfg.pause_limit_ms <= pwdata[TIME_W-1:0];
                REG_MAX_SPEECH:  r_cfg.max_speech_ms  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_VAD_ENABLE:  prdata = APB_DATA_W'(r_cfg.vad_enable);
            REG_RMS_LEVEL:   prdata = APB_DATA_W'(r_cfg.rms_level);
            REG_PAUSE_LIMIT: prdata = APB_DATA_W'(r_cfg.pause_limit_ms);
            REG_MAX_SPEECH:  prdata = APB_DATA_W'(r_cfg.max_speech_ms);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: sv/evsb_energy.sv
// ----------------------------------------------------------------------------
// evsb_energy
// Squares samples, accumulates chunk energy against the scaled threshold
// and classifies each finished chunk as silent or loud.
// ----------------------------------------------------------------------------
module evsb_energy (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  evsb_pkg::t_tag                i_tag,
    input  logic [evsb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [evsb_pkg::THR_W-1:0]    i_rms_level,
    output evsb_pkg::t_chunk              o_chunk
);
    import evsb_pkg::*;

    logic [SAMPLE_W-1:0] w_mag;

    logic                r_s1_valid;
    t_tag                r_s1_tag;
    logic [SQ_W-1:0]     r_s1_sq;
    logic [THR2_W-1:0]   r_s1_thr2;

    logic [SUM_W-1:0]    r_sum;
    logic [TACC_W-1:0]   r_tacc;
    logic [CNT_W-1:0]    r_count;
    logic                w_take;
    logic [SUM_W-1:0]    n_sum;
    logic [TACC_W-1:0]   n_tacc;
    logic [CNT_W-1:0]    n_count;

    logic                r_s2_valid;
    t_tag                r_s2_tag;
    logic [SUM_W-1:0]    r_s2_sum;
    logic [TACC_W-1:0]   r_s2_tacc;

    t_chunk              r_s3;

    assign w_mag = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
        end
        if (i_adv) begin
            r_s1_tag  <= i_tag;
            r_s1_sq   <= SQ_W'(w_mag) * SQ_W'(w_mag);
            r_s1_thr2 <= THR2_W'(i_rms_level) * THR2_W'(i_rms_level);
        end
    end

    assign w_take  = r_count < CNT_W'(MAX_CHUNK_SAMPLES);
    assign n_sum   = w_take ? r_sum + SUM_W'(r_s1_sq) : r_sum;
    assign n_tacc  = w_take ? r_tacc + TACC_W'(r_s1_thr2) : r_tacc;
    assign n_count = w_take ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_tacc     <= '0;
            r_count    <= '0;
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                if (r_s1_tag.chunk_end) begin
                    r_sum   <= '0;
                    r_tacc  <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_tacc  <= n_tacc;
                    r_count <= n_count;
                end
            end
        end
        if (i_adv) begin
            r_s2_tag  <= r_s1_tag;
            r_s2_sum  <= n_sum;
            r_s2_tacc <= n_tacc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (i_adv) begin
            r_s3.valid <= r_s2_valid;
        end
        if (i_adv) begin
            r_s3.tag    <= r_s2_tag;
            r_s3.silent <= TACC_W'(r_s2_sum) < r_s2_tacc;
        end
    end

    assign o_chunk = r_s3;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CHUNK_SAMPLES))
        else $error("chunk sample count beyond its limit");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_s1_valid && r_s1_tag.chunk_end) |=> (r_count == '0 && r_sum == '0))
        else $error("accumulators not cleared after chunk end");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_count) && $stable(r_s3))
        else $error("pipeline moved while held");

endmodule

FILE: sv/energy_vad_sentence_break.sv
// ----------------------------------------------------------------------------
// energy_vad_sentence_break
// Energy voice activity detector that classifies audio chunks and decides
// sentence breaks from accumulated silence and speech time.
// ----------------------------------------------------------------------------
// A result word passes the input register, then the square, accumulate, compare
// and time update steps after the chunk's last sample is accepted.
// Throughput: one sample word per cycle; the input stalls only while a
// finished result is held at the output and another chunk end is ready.
// Reset is synchronous and active low; it clears the pipeline, the chunk
// accumulators and both time counters and loads the register defaults.
// ----------------------------------------------------------------------------
module energy_vad_sentence_break (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [evsb_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_chunk_end,
    input  logic [evsb_pkg::MS_W-1:0]       i_chunk_ms,
    input  logic                            i_has_text,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_chunk_silent,
    output logic                            o_sentence_break,
    output logic [evsb_pkg::TIME_W-1:0]     o_silence_time,
    output logic [evsb_pkg::TIME_W-1:0]     o_speech_time,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [evsb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [evsb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [evsb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import evsb_pkg::*;

    t_cfg                w_cfg;
    logic                w_adv;
    logic                w_load;

    logic                r_s0_valid;
    t_tag                r_s0_tag;
    logic [SAMPLE_W-1:0] r_s0_sample;
    t_chunk              w_chunk;

    logic [TIME_W-1:0]   r_sil;
    logic [TIME_W-1:0]   r_sp;
    logic [TIME_W:0]     w_sil_sum;
    logic [TIME_W:0]     w_sp_sum;
    logic [TIME_W-1:0]   n_sil;
    logic [TIME_W-1:0]   n_sp;
    logic                n_brk;

    logic                r_out_valid;
    logic                r_out_silent;
    logic                r_out_brk;
    logic [TIME_W-1:0]   r_out_sil;
    logic [TIME_W-1:0]   r_out_sp;

    evsb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = !(w_chunk.valid && w_chunk.tag.chunk_end && r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;
    assign w_load     = w_adv && w_chunk.valid && w_chunk.tag.chunk_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_in_valid;
        end
        if (w_adv) begin
            r_s0_tag.chunk_end <= i_chunk_end;
            r_s0_tag.chunk_ms  <= i_chunk_ms;
            r_s0_tag.has_text  <= i_has_text;
            r_s0_sample        <= i_sample;
        end
    end

    evsb_energy u_energy (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (r_s0_valid),
        .i_tag       (r_s0_tag),
        .i_sample    (r_s0_sample),
        .i_rms_level (w_cfg.rms_level),
        .o_chunk     (w_chunk)
    );

    assign w_sil_sum = {1'b0, r_sil} + (TIME_W+1)'(w_chunk.tag.chunk_ms);
    assign w_sp_sum  = {1'b0, r_sp} + (TIME_W+1)'(w_chunk.tag.chunk_ms);

    always_comb begin
        if (w_chunk.silent) begin
            n_sil = w_sil_sum[TIME_W] ? TIME_MAX : w_sil_sum[TIME_W-1:0];
            n_sp  = r_sp;
        end else begin
            n_sil = '0;
            n_sp  = w_sp_sum[TIME_W] ? TIME_MAX : w_sp_sum[TIME_W-1:0];
        end
        n_brk = w_cfg.vad_enable && w_chunk.tag.has_text &&
                (n_sil >= w_cfg.pause_limit_ms || n_sp >= w_cfg.max_speech_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sil       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_sil       <= n_brk ? '0 : n_sil;
            r_sp        <= n_brk ? '0 : n_sp;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_silent <= w_chunk.silent;
            r_out_brk    <= n_brk;
            r_out_sil    <= n_sil;
            r_out_sp     <= n_sp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chunk_silent   = r_out_silent;
    assign o_sentence_break = r_out_brk;
    assign o_silence_time   = r_out_sil;
    assign o_speech_time    = r_out_sp;

    a_break_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_brk) |=> (r_sil == '0 && r_sp == '0))
        else $error("times not cleared after a sentence break");

    a_loud_no_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_chunk_silent) |-> (o_silence_time == '0))
        else $error("loud chunk reported with silence time");

    a_break_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_brk) |-> w_cfg.vad_enable)
        else $error("sentence break while detector disabled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule
